@@ rtl/tmce_pkg.sv @@
// ----------------------------------------------------------------------------
// tmce_pkg: shared types and constants of the text console engine
// command word, geometry, queue status and engine state types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmce_pkg;

	// field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;
	localparam int CFG_W  = 8;
	localparam int IDX_W  = 3;

	// geometry limits
	localparam int COLS_MIN = 2;
	localparam int COLS_MAX = 80;
	localparam int ROWS_MIN = 2;
	localparam int ROWS_MAX = 25;

	// cell and character codes
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
	localparam logic [7:0]        CH_BS      = 8'h08;
	localparam logic [7:0]        CH_TAB     = 8'h09;
	localparam logic [7:0]        CH_LF      = 8'h0A;
	localparam logic [7:0]        CH_CR      = 8'h0D;
	localparam logic [7:0]        CH_SPACE   = 8'h20;
	localparam int                TAB_STEP   = 4;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_COLUMNS   = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROWS      = 3'd1;
	localparam logic [IDX_W-1:0] REG_DFLT_FG   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DFLT_BG   = 3'd3;
	localparam logic [IDX_W-1:0] REG_FILL_ATTR = 3'd4;

	// reset values of the registers
	localparam logic [COL_W-1:0] RST_COLUMNS   = 7'd80;
	localparam logic [ROW_W-1:0] RST_ROWS      = 5'd25;
	localparam logic [3:0]       RST_DFLT_FG   = 4'd7;
	localparam logic [3:0]       RST_DFLT_BG   = 4'd0;
	localparam logic [7:0]       RST_FILL_ATTR = 8'h0F;

	localparam int Q_DEPTH = 2;

	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUT,
		OP_BS,
		OP_TAB,
		OP_CR,
		OP_LF,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic [3:0] fg;
		logic [3:0] bg;
		logic [POS_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [COL_W-1:0] cols;
		logic [ROW_W-1:0] rows;
		logic [POS_W-1:0] cells;
		logic [POS_W-1:0] keep;
	} geom_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR,
		ST_COPY,
		ST_FILL,
		ST_READ,
		ST_DONE
	} bstate_t;

endpackage

`default_nettype wire

@@ rtl/text_mode_console_engine.sv @@
// ----------------------------------------------------------------------------
// text_mode_console_engine: character-cell text console
// screen store of attribute/character cells with cursor, control characters,
// scrolling, clear and cell read-back
// ----------------------------------------------------------------------------
//
// channel   dir  handshake              payload
// --------  ---  ---------------------  -----------------------------------------
// request   in   req_valid / req_stall  req_type char_code fg_color bg_color
//                                       cell_index
// response  out  rsp_valid / rsp_stall  cursor_pos cell_written write_addr
//                                       write_cell did_scroll read_cell
// config    in   cfg_en                 cfg_index cfg_data
//
// - a plain put, cursor move or no-op passes through the engine states pop,
//   execute and done; a read adds a state for the registered store read
// - each scroll adds a row-up copy pass and a bottom-row fill pass, set by
//   the single write and single read port of the screen store
// - clear walks rows*columns cells, one per cycle
// - after reset a clearing pass blanks all MAX_CELLS cells of the store;
//   req_stall stays high until it finishes
// - a two-word queue takes requests while the engine works; a finished word
//   waits in the output register while the engine starts on the next one
//
`timescale 1ns / 1ps
`default_nettype none

module text_mode_console_engine #(
	parameter int unsigned MAX_CELLS = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  char_code,
	input  wire logic [3:0]  fg_color,
	input  wire logic [3:0]  bg_color,
	input  wire logic [10:0] cell_index,

	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [10:0]      cursor_pos,
	output logic             cell_written,
	output logic [10:0]      write_addr,
	output logic [15:0]      write_cell,
	output logic             did_scroll,
	output logic [15:0]      read_cell,

	input  wire logic        cfg_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	// widest screen that still leaves two rows
	localparam int COL_CAP = (int'(MAX_CELLS / 2) < tmce_pkg::COLS_MAX) ?
		int'(MAX_CELLS / 2) : tmce_pkg::COLS_MAX;

	// configuration registers
	logic [6:0] columns_q;
	logic [4:0] rows_q;
	logic [3:0] dflt_fg_q;
	logic [3:0] dflt_bg_q;
	logic [7:0] fill_attr_q;

	// geometry
	logic [4:0]        rows_lim [128];
	logic [6:0]        cols_c;
	logic [4:0]        rows_c;
	logic [4:0]        rows_e;
	tmce_pkg::geom_t   geom_d;
	tmce_pkg::geom_t   geom_s1;

	// front to queue to engine
	logic              push;
	tmce_pkg::cmd_t    push_cmd;
	logic              pop;
	tmce_pkg::cmd_t    pop_cmd;
	tmce_pkg::q_stat_t q_stat;
	logic              init_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q   <= tmce_pkg::RST_COLUMNS;
			rows_q      <= tmce_pkg::RST_ROWS;
			dflt_fg_q   <= tmce_pkg::RST_DFLT_FG;
			dflt_bg_q   <= tmce_pkg::RST_DFLT_BG;
			fill_attr_q <= tmce_pkg::RST_FILL_ATTR;
		end else if (cfg_en) begin
			unique case (cfg_index)
				tmce_pkg::REG_COLUMNS:   columns_q   <= cfg_data[6:0];
				tmce_pkg::REG_ROWS:      rows_q      <= cfg_data[4:0];
				tmce_pkg::REG_DFLT_FG:   dflt_fg_q   <= cfg_data[3:0];
				tmce_pkg::REG_DFLT_BG:   dflt_bg_q   <= cfg_data[3:0];
				tmce_pkg::REG_FILL_ATTR: fill_attr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// row limit per column count so the screen fits the store
	for (genvar g = 0; g < 128; g++) begin : g_rows_lim
		localparam int LIM = int'(MAX_CELLS) / ((g < 2) ? 2 : g);
		assign rows_lim[g] = 5'((LIM > tmce_pkg::ROWS_MAX) ? tmce_pkg::ROWS_MAX : LIM);
	end

	always_comb begin
		if (columns_q < 7'(tmce_pkg::COLS_MIN)) begin
			cols_c = 7'(tmce_pkg::COLS_MIN);
		end else if (columns_q > 7'(COL_CAP)) begin
			cols_c = 7'(COL_CAP);
		end else begin
			cols_c = columns_q;
		end
		if (rows_q < 5'(tmce_pkg::ROWS_MIN)) begin
			rows_c = 5'(tmce_pkg::ROWS_MIN);
		end else if (rows_q > 5'(tmce_pkg::ROWS_MAX)) begin
			rows_c = 5'(tmce_pkg::ROWS_MAX);
		end else begin
			rows_c = rows_q;
		end
		rows_e = (rows_c > rows_lim[cols_c]) ? rows_lim[cols_c] : rows_c;

		geom_d.cols  = cols_c;
		geom_d.rows  = rows_e;
		geom_d.cells = 11'({6'd0, rows_e} * {4'd0, cols_c});
		geom_d.keep  = geom_d.cells - {4'd0, cols_c};
	end

	// geometry is registered and settles in the cycle after a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_s1 <= '0;
		end else begin
			geom_s1 <= geom_d;
		end
	end

	tmce_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.char_code  (char_code),
		.fg_color   (fg_color),
		.bg_color   (bg_color),
		.cell_index (cell_index),
		.q_stat     (q_stat),
		.init_busy  (init_busy),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	tmce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.stat     (q_stat)
	);

	tmce_back #(
		.MAX_CELLS (MAX_CELLS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_cmd        (pop_cmd),
		.q_stat       (q_stat),
		.q_pop        (pop),
		.geom         (geom_s1),
		.dflt_fg      (dflt_fg_q),
		.dflt_bg      (dflt_bg_q),
		.fill_attr    (fill_attr_q),
		.init_busy    (init_busy),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.cursor_pos   (cursor_pos),
		.cell_written (cell_written),
		.write_addr   (write_addr),
		.write_cell   (write_cell),
		.did_scroll   (did_scroll),
		.read_cell    (read_cell)
	);

endmodule

`default_nettype wire

@@ rtl/tmce_front.sv @@
// ----------------------------------------------------------------------------
// tmce_front: request intake
// accepts request words and sorts them into engine commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmce_front (
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [7:0]         char_code,
	input  wire logic [3:0]         fg_color,
	input  wire logic [3:0]         bg_color,
	input  wire logic [10:0]        cell_index,
	input  wire tmce_pkg::q_stat_t  q_stat,
	input  wire logic               init_busy,
	output logic                    push,
	output tmce_pkg::cmd_t          push_cmd
);

	assign req_stall = q_stat.full || init_busy;
	assign push      = req_valid && !req_stall;

	always_comb begin
		push_cmd.ch  = char_code;
		push_cmd.fg  = fg_color;
		push_cmd.bg  = bg_color;
		push_cmd.idx = cell_index;
		push_cmd.op  = tmce_pkg::OP_NOP;
		unique case (req_type)
			tmce_pkg::REQ_PUT: begin
				unique case (char_code)
					tmce_pkg::CH_BS:  push_cmd.op = tmce_pkg::OP_BS;
					tmce_pkg::CH_TAB: push_cmd.op = tmce_pkg::OP_TAB;
					tmce_pkg::CH_CR:  push_cmd.op = tmce_pkg::OP_CR;
					tmce_pkg::CH_LF:  push_cmd.op = tmce_pkg::OP_LF;
					default: begin
						// other control bytes leave everything alone
						push_cmd.op = (char_code < tmce_pkg::CH_SPACE) ?
							tmce_pkg::OP_NOP : tmce_pkg::OP_PUT;
					end
				endcase
			end
			tmce_pkg::REQ_CLEAR: push_cmd.op = tmce_pkg::OP_CLEAR;
			tmce_pkg::REQ_READ:  push_cmd.op = tmce_pkg::OP_READ;
			default:             push_cmd.op = tmce_pkg::OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/tmce_queue.sv @@
// ----------------------------------------------------------------------------
// tmce_queue: command queue
// short fifo between request intake and the cell engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmce_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tmce_pkg::cmd_t    push_cmd,
	input  wire logic              pop,
	output tmce_pkg::cmd_t         pop_cmd,
	output tmce_pkg::q_stat_t      stat
);

	localparam int DEPTH = tmce_pkg::Q_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	tmce_pkg::cmd_t  ent_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;

	assign stat.full  = (fill_q == CW'(DEPTH));
	assign stat.empty = (fill_q == '0);
	assign pop_cmd    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("word pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("word popped from an empty queue");

endmodule

`default_nettype wire

@@ rtl/tmce_back.sv @@
// ----------------------------------------------------------------------------
// tmce_back: cell engine
// owns the screen store and the cursor, runs puts, scrolls, clears and reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmce_back #(
	parameter int unsigned MAX_CELLS = 2048
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tmce_pkg::cmd_t     q_cmd,
	input  wire tmce_pkg::q_stat_t  q_stat,
	output logic                    q_pop,
	input  wire tmce_pkg::geom_t    geom,
	input  wire logic [3:0]         dflt_fg,
	input  wire logic [3:0]         dflt_bg,
	input  wire logic [7:0]         fill_attr,
	output logic                    init_busy,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [10:0]             cursor_pos,
	output logic                    cell_written,
	output logic [10:0]             write_addr,
	output logic [15:0]             write_cell,
	output logic                    did_scroll,
	output logic [15:0]             read_cell
);

	localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CNT_W = ($clog2(MAX_CELLS) > 11) ? $clog2(MAX_CELLS) : 11;

	tmce_pkg::bstate_t state_q, state_d;
	tmce_pkg::cmd_t    cmd_q;

	logic [15:0]       store_q [MAX_CELLS];
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [15:0]       mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [15:0]       rdata_s1;

	logic [6:0]        col_q;
	logic [4:0]        row_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_s1;
	logic [AW-1:0]     dst_s1;

	logic              written_q;
	logic [10:0]       waddr_q;
	logic [15:0]       wcell_q;
	logic              scrolled_q;
	logic [15:0]       rcell_q;

	logic              rsp_valid_q;
	logic [10:0]       pos_q;
	logic              written_o_q;
	logic [10:0]       waddr_o_q;
	logic [15:0]       wcell_o_q;
	logic              scrolled_o_q;
	logic [15:0]       rcell_o_q;

	// cursor move
	logic [6:0]  col_sat;
	logic [4:0]  row_sat;
	logic [7:0]  col_mv;
	logic [5:0]  row_mv;
	logic [7:0]  col_w1, col_w2;
	logic        inc1, inc2;
	logic [5:0]  row_fin;
	logic        need_scroll;
	logic [10:0] wpos;
	logic [15:0] wcell;
	logic [3:0]  fg_eff, bg_eff;
	logic        rd_issue;
	logic        more_scroll;
	logic [4:0]  row_dec;
	logic        rsp_free;
	logic        idx_ok;
	logic        sweep_end;
	logic [10:0] pos;

	assign init_busy = (state_q == tmce_pkg::ST_INIT);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign idx_ok    = (int'(cmd_q.idx) < int'(MAX_CELLS));
	assign rd_issue  = (cnt_q < CNT_W'(geom.keep));
	assign sweep_end = (cnt_q == CNT_W'(geom.cells - 11'd1));
	assign row_dec   = row_q - 5'd1;
	assign more_scroll = (row_dec >= geom.rows);
	assign pos = 11'({6'd0, row_q} * {4'd0, geom.cols}) + {4'd0, col_q};

	always_comb begin
		col_sat = (col_q >= geom.cols) ? geom.cols - 7'd1 : col_q;
		row_sat = (row_q >= geom.rows) ? geom.rows - 5'd1 : row_q;
		col_mv  = {1'b0, col_sat};
		row_mv  = {1'b0, row_sat};
		unique case (cmd_q.op)
			tmce_pkg::OP_PUT: col_mv = col_mv + 8'd1;
			tmce_pkg::OP_BS: begin
				if (col_sat != 7'd0) begin
					col_mv = col_mv - 8'd1;
				end else if (row_sat != 5'd0) begin
					// back over the line start onto the row above
					row_mv = row_mv - 6'd1;
					col_mv = {1'b0, geom.cols} - 8'd2;
				end
			end
			tmce_pkg::OP_TAB: col_mv = col_mv + 8'(tmce_pkg::TAB_STEP);
			tmce_pkg::OP_CR:  col_mv = 8'd0;
			tmce_pkg::OP_LF: begin
				col_mv = 8'd0;
				row_mv = row_mv + 6'd1;
			end
			tmce_pkg::OP_CLEAR: begin
				col_mv = 8'd0;
				row_mv = 6'd0;
			end
			default: ;
		endcase
		// a tab can wrap twice on narrow screens
		inc1   = (col_mv >= {1'b0, geom.cols});
		col_w1 = inc1 ? col_mv - {1'b0, geom.cols} : col_mv;
		inc2   = (col_w1 >= {1'b0, geom.cols});
		col_w2 = inc2 ? col_w1 - {1'b0, geom.cols} : col_w1;
		row_fin = row_mv + {5'd0, inc1} + {5'd0, inc2};
		need_scroll = (row_fin >= {1'b0, geom.rows});

		fg_eff = (cmd_q.fg != 4'd0) ? cmd_q.fg : dflt_fg;
		bg_eff = (cmd_q.bg != 4'd0) ? cmd_q.bg : dflt_bg;
		wcell  = {bg_eff, fg_eff, cmd_q.ch};
		wpos   = 11'({6'd0, row_sat} * {4'd0, geom.cols}) + {4'd0, col_sat};
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = AW'(cnt_q);
		mem_wdata = tmce_pkg::BLANK_CELL;
		mem_raddr = '0;
		unique case (state_q)
			tmce_pkg::ST_INIT: begin
				mem_we = 1'b1;
				if (cnt_q == CNT_W'(MAX_CELLS - 1)) begin
					state_d = tmce_pkg::ST_IDLE;
				end
			end
			tmce_pkg::ST_IDLE: begin
				if (!q_stat.empty) begin
					q_pop   = 1'b1;
					state_d = tmce_pkg::ST_EXEC;
				end
			end
			tmce_pkg::ST_EXEC: begin
				unique case (cmd_q.op)
					tmce_pkg::OP_CLEAR: state_d = tmce_pkg::ST_CLEAR;
					tmce_pkg::OP_READ: begin
						mem_raddr = AW'(cmd_q.idx);
						state_d   = tmce_pkg::ST_READ;
					end
					tmce_pkg::OP_PUT: begin
						mem_we    = 1'b1;
						mem_waddr = AW'(wpos);
						mem_wdata = wcell;
						state_d   = need_scroll ? tmce_pkg::ST_COPY : tmce_pkg::ST_DONE;
					end
					default: begin
						state_d = need_scroll ? tmce_pkg::ST_COPY : tmce_pkg::ST_DONE;
					end
				endcase
			end
			tmce_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_end) begin
					state_d = tmce_pkg::ST_DONE;
				end
			end
			tmce_pkg::ST_COPY: begin
				// read one row ahead, write it back in the next cycle
				if (rd_issue) begin
					mem_raddr = AW'(cnt_q + CNT_W'(geom.cols));
				end
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = dst_s1;
					mem_wdata = rdata_s1;
				end
				if (!rd_issue && !pend_s1) begin
					state_d = tmce_pkg::ST_FILL;
				end
			end
			tmce_pkg::ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = {fill_attr, tmce_pkg::CH_SPACE};
				if (sweep_end) begin
					state_d = more_scroll ? tmce_pkg::ST_COPY : tmce_pkg::ST_DONE;
				end
			end
			tmce_pkg::ST_READ: state_d = tmce_pkg::ST_DONE;
			tmce_pkg::ST_DONE: begin
				if (rsp_free) begin
					state_d = tmce_pkg::ST_IDLE;
				end
			end
			default: state_d = tmce_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmce_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == tmce_pkg::ST_COPY) && rd_issue;
			case (state_q)
				tmce_pkg::ST_INIT, tmce_pkg::ST_CLEAR: cnt_q <= cnt_q + CNT_W'(1);
				tmce_pkg::ST_EXEC: begin
					cnt_q <= '0;
					col_q <= col_w2[6:0];
					row_q <= row_fin[4:0];
				end
				tmce_pkg::ST_COPY: begin
					if (rd_issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				tmce_pkg::ST_FILL: begin
					if (sweep_end) begin
						cnt_q <= '0;
						row_q <= row_dec;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
			if ((state_q == tmce_pkg::ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		dst_s1 <= AW'(cnt_q);
		case (state_q)
			tmce_pkg::ST_IDLE: begin
				if (q_pop) begin
					cmd_q <= q_cmd;
				end
			end
			tmce_pkg::ST_EXEC: begin
				written_q  <= (cmd_q.op == tmce_pkg::OP_PUT);
				waddr_q    <= (cmd_q.op == tmce_pkg::OP_PUT) ? wpos : 11'd0;
				wcell_q    <= (cmd_q.op == tmce_pkg::OP_PUT) ? wcell : 16'd0;
				scrolled_q <= 1'b0;
				rcell_q    <= 16'd0;
			end
			tmce_pkg::ST_FILL: begin
				if (sweep_end) begin
					scrolled_q <= 1'b1;
				end
			end
			tmce_pkg::ST_READ: rcell_q <= idx_ok ? rdata_s1 : 16'd0;
			tmce_pkg::ST_DONE: begin
				if (rsp_free) begin
					pos_q        <= pos;
					written_o_q  <= written_q;
					waddr_o_q    <= waddr_q;
					wcell_o_q    <= wcell_q;
					scrolled_o_q <= scrolled_q;
					rcell_o_q    <= rcell_q;
				end
			end
			default: ;
		endcase
	end

	// screen store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= store_q[mem_raddr];
	end

	assign rsp_valid    = rsp_valid_q;
	assign cursor_pos   = pos_q;
	assign cell_written = written_o_q;
	assign write_addr   = waddr_o_q;
	assign write_cell   = wcell_o_q;
	assign did_scroll   = scrolled_o_q;
	assign read_cell    = rcell_o_q;

	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tmce_pkg::ST_INIT) |=> (state_q != tmce_pkg::ST_INIT))
		else $error("store init sweep restarted");

	a_copy_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == tmce_pkg::ST_COPY))
		else $error("scroll copy write pending outside the copy pass");

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (int'(mem_waddr) < int'(MAX_CELLS)))
		else $error("store write beyond its depth");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == tmce_pkg::ST_DONE))
		else $error("response raised outside the done state");

endmodule

`default_nettype wire
